>>> rtl/pid_pkg.sv
package pid_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned DriveW  = 17;
  localparam int unsigned IntegW  = 26;
  localparam int unsigned FracW   = 8;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [DriveW-1:0]  drive_t;
  typedef logic        [LimitW-1:0]  cfg_data_t;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4,
    REG_DEAD_BAND      = 3'd5,
    REG_DEAD_BAND_EN   = 3'd6
  } cfg_idx_t;

endpackage

>>> rtl/positional_pid_controller.sv
// positional pid with integral clamp and deadband hold
// an accepted sample is registered in the input, product and sum stages, then at the output
// throughput: one transaction per cycle while out_ready is high; products,
//   integral update and output saturation each take one pipeline stage
// reset: synchronous active-low rst_n clears the configuration registers,
//   integral, last error, held drive and all pipeline valid bits
module positional_pid_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pid_pkg::sample_t    in_measured_value,
  input  pid_pkg::sample_t    in_target_value,
  output logic                out_valid,
  input  logic                out_ready,
  output pid_pkg::drive_t     out_drive,
  output logic                out_held,
  input  logic                cfg_we,
  input  pid_pkg::cfg_idx_t   cfg_index,
  input  pid_pkg::cfg_data_t  cfg_wdata
);
  import pid_pkg::*;

  // configuration
  logic signed [GainW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LimitW-1:0]       integral_limit_r, output_limit_r, dead_band_r;
  logic                    dead_band_enable_r;

  // controller state
  logic signed [ErrW-1:0]   prev_err_r;
  logic signed [IntegW-1:0] integ_r;
  logic signed [DriveW-1:0] held_drive_r;

  // pipeline registers
  logic                   v1_r, v2_r, v3_r;
  logic signed [ErrW-1:0] err1_r;
  logic signed [ErrW:0]   diff1_r;
  logic                   hold1_r, hold2_r, hold3_r;
  logic signed [32:0]     p2_r, ip2_r;
  logic signed [33:0]     d2_r;
  logic signed [34:0]     pd3_r;
  logic                   out_valid_r, out_held_r;
  logic signed [DriveW-1:0] out_drive_r;

  logic en1, en2, en3, en4, in_fire;

  logic signed [ErrW-1:0]   err_nxt;
  logic        [ErrW-1:0]   mag_nxt;
  logic signed [ErrW:0]     diff_nxt;
  logic                     hold_nxt;
  logic signed [33:0]       isum;
  logic signed [33:0]       ilim;
  logic signed [IntegW-1:0] integ_nxt;
  logic signed [35:0]       total;
  logic signed [27:0]       shifted;
  logic signed [27:0]       olim;
  logic signed [DriveW-1:0] drive_nxt;

  // each stage moves when the one after it is empty or moving
  assign en4     = !out_valid_r || out_ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign in_ready = en1;
  assign in_fire = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r           <= '0;
      gain_i_r           <= '0;
      gain_d_r           <= '0;
      integral_limit_r   <= '0;
      output_limit_r     <= '0;
      dead_band_r        <= '0;
      dead_band_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:         gain_p_r           <= signed'(cfg_wdata);
        REG_GAIN_I:         gain_i_r           <= signed'(cfg_wdata);
        REG_GAIN_D:         gain_d_r           <= signed'(cfg_wdata);
        REG_INTEGRAL_LIMIT: integral_limit_r   <= cfg_wdata;
        REG_OUTPUT_LIMIT:   output_limit_r     <= cfg_wdata;
        REG_DEAD_BAND:      dead_band_r        <= cfg_wdata;
        REG_DEAD_BAND_EN:   dead_band_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input side: error, deadband test, error difference
  always_comb begin
    err_nxt  = ErrW'(in_target_value) - ErrW'(in_measured_value);
    mag_nxt  = err_nxt[ErrW-1] ? unsigned'(-err_nxt) : unsigned'(err_nxt);
    hold_nxt = dead_band_enable_r && (mag_nxt <= {1'b0, dead_band_r});
    diff_nxt = (ErrW+1)'(err_nxt) - (ErrW+1)'(prev_err_r);
  end

  // integral update with symmetric clamp
  always_comb begin
    isum = 34'(integ_r) + 34'(ip2_r);
    ilim = signed'({10'b0, integral_limit_r, {FracW{1'b0}}});
    if (isum > ilim) begin
      integ_nxt = IntegW'(ilim);
    end else if (isum < -ilim) begin
      integ_nxt = IntegW'(-ilim);
    end else begin
      integ_nxt = IntegW'(isum);
    end
  end

  // sum, floor shift and output saturation
  always_comb begin
    total   = 36'(pd3_r) + 36'(integ_r);
    shifted = 28'(total >>> FracW);
    olim    = signed'({12'b0, output_limit_r});
    if (shifted > olim) begin
      drive_nxt = DriveW'(olim);
    end else if (shifted < -olim) begin
      drive_nxt = DriveW'(-olim);
    end else begin
      drive_nxt = DriveW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      held_drive_r <= '0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (in_fire) begin
        prev_err_r <= err_nxt;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
        if (v2_r && !hold2_r) begin
          integ_r <= integ_nxt;
        end
      end
      if (en4) begin
        out_valid_r <= v3_r;
        if (v3_r && !hold3_r) begin
          held_drive_r <= drive_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err1_r  <= err_nxt;
      diff1_r <= diff_nxt;
      hold1_r <= hold_nxt;
    end
    if (en2 && v1_r) begin
      p2_r    <= 33'(gain_p_r) * 33'(err1_r);
      ip2_r   <= 33'(gain_i_r) * 33'(err1_r);
      d2_r    <= 34'(gain_d_r) * 34'(diff1_r);
      hold2_r <= hold1_r;
    end
    if (en3 && v2_r) begin
      pd3_r   <= 35'(p2_r) + 35'(d2_r);
      hold3_r <= hold2_r;
    end
    if (en4 && v3_r) begin
      out_drive_r <= hold3_r ? held_drive_r : drive_nxt;
      out_held_r  <= hold3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_held  = out_held_r;

`ifndef SYNTHESIS
  // a computed drive never leaves the output bound
  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_held_r |->
      (18'(out_drive_r) <= signed'({2'b0, output_limit_r})) &&
      (18'(out_drive_r) >= -signed'({2'b0, output_limit_r})))
    else $error("drive outside output limit");

  // a held result repeats the last computed drive
  a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_held_r |-> out_drive_r == held_drive_r)
    else $error("held drive mismatch");

  // with deadband off nothing is held
  a_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !dead_band_enable_r |-> !out_held_r)
    else $error("held while deadband disabled");

  // a held transaction leaves the integral alone
  a_integ_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && en3 && hold2_r |=> $stable(integ_r))
    else $error("integral changed on held transaction");
`endif

endmodule

>>> bench/tb_positional_pid_controller.sv
module tb_positional_pid_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_pkg::*;

  localparam int unsigned RandomItems   = 1030;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned IdlePct       = 23;
  localparam logic [2:0]  RegUnused     = 3'd7;

  typedef struct {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimitW-1:0]       integ_lim;
    logic [LimitW-1:0]       out_lim;
    logic [LimitW-1:0]       band;
    logic                    band_en;
  } pid_settings_t;

  typedef struct {
    drive_t drive;
    logic   held;
  } drive_result_t;

  typedef enum {STIM_SPREAD, STIM_TRACK, STIM_EDGES} stim_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sample_t   in_measured_value = '0;
  sample_t   in_target_value = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  drive_t    out_drive;
  logic      out_held;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = REG_GAIN_P;
  cfg_data_t cfg_wdata = '0;

  // controller copy kept by the bench
  logic signed [GainW-1:0]  ctl_gain_p = '0;
  logic signed [GainW-1:0]  ctl_gain_i = '0;
  logic signed [GainW-1:0]  ctl_gain_d = '0;
  logic [LimitW-1:0]        ctl_integ_lim = '0;
  logic [LimitW-1:0]        ctl_out_lim = '0;
  logic [LimitW-1:0]        ctl_band = '0;
  logic                     ctl_band_en = 1'b0;
  logic signed [ErrW:0]     ctl_last_err = '0;
  logic signed [IntegW-1:0] ctl_integ = '0;
  logic signed [DriveW:0]   ctl_last_drive = '0;

  drive_result_t pending_drives[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            no_idle = 1'b0;
  bit            hold_off_req = 1'b0;

  positional_pid_controller i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_value (in_measured_value),
    .in_target_value   (in_target_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive         (out_drive),
    .out_held          (out_held),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint limit_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic drive_result_t predict_drive(input sample_t meas, input sample_t targ);
    drive_result_t res;
    longint err;
    longint isum;
    longint acc;
    longint drv;
    err = longint'(targ) - longint'(meas);
    res.held = ctl_band_en && ((err < 0 ? -err : err) <= longint'(ctl_band));
    if (res.held) begin
      drv = longint'(ctl_last_drive);
    end else begin
      isum = limit_mag(longint'(ctl_integ) + longint'(ctl_gain_i) * err,
                       longint'(ctl_integ_lim) << FracW);
      acc = longint'(ctl_gain_p) * err + isum
          + longint'(ctl_gain_d) * (err - longint'(ctl_last_err));
      // arithmetic shift of a signed value rounds toward minus infinity
      drv = limit_mag(acc >>> FracW, longint'(ctl_out_lim));
      ctl_integ = isum[IntegW-1:0];
      ctl_last_drive = drv[DriveW:0];
    end
    ctl_last_err = err[ErrW:0];
    res.drive = drv[DriveW-1:0];
    return res;
  endfunction

  function automatic sample_t to_sample(input int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_edge_sample();
    case ($urandom_range(6))
      0: return sample_t'(-32768);
      1: return sample_t'(-32767);
      2: return sample_t'(-1);
      3: return sample_t'(0);
      4: return sample_t'(1);
      5: return sample_t'(32766);
      default: return sample_t'(32767);
    endcase
  endfunction

  function automatic logic signed [GainW-1:0] pick_gain();
    case ($urandom_range(5))
      0: return GainW'(32767);
      1: return GainW'(-32768);
      2: return '0;
      3, 4: return GainW'($urandom_range(1024) - 512);
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic logic [LimitW-1:0] pick_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2, 3: return LimitW'($urandom_range(300));
      default: return LimitW'($urandom);
    endcase
  endfunction

  function automatic logic [LimitW-1:0] pick_band();
    case ($urandom_range(5))
      0: return '0;
      1, 2, 3: return LimitW'($urandom_range(40));
      4: return '1;
      default: return LimitW'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input cfg_data_t value);
    cfg_we <= 1'b1;
    cfg_index <= cfg_idx_t'(idx);
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:         ctl_gain_p = value;
      REG_GAIN_I:         ctl_gain_i = value;
      REG_GAIN_D:         ctl_gain_d = value;
      REG_INTEGRAL_LIMIT: ctl_integ_lim = value;
      REG_OUTPUT_LIMIT:   ctl_out_lim = value;
      REG_DEAD_BAND:      ctl_band = value;
      REG_DEAD_BAND_EN:   ctl_band_en = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input pid_settings_t s);
    write_reg(REG_GAIN_P, s.gain_p);
    write_reg(REG_GAIN_I, s.gain_i);
    write_reg(REG_GAIN_D, s.gain_d);
    write_reg(REG_INTEGRAL_LIMIT, s.integ_lim);
    write_reg(REG_OUTPUT_LIMIT, s.out_lim);
    write_reg(REG_DEAD_BAND, s.band);
    // junk in the upper bits must not matter
    write_reg(REG_DEAD_BAND_EN, {15'($urandom), s.band_en});
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input sample_t meas, input sample_t targ);
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_measured_value <= meas;
    in_target_value <= targ;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(predict_drive(meas, targ));
  endtask

  // wait until every transaction is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_hold_from_reset();
    pid_settings_t s;
    s = '{default: 0};
    s.band = 5;
    s.band_en = 1'b1;
    load_settings(s);
    // held drive comes from reset before anything was computed
    send_sample(10, 10);
    send_sample(0, 5);
    send_sample(7, 2);
    send_sample(0, 6);
    settle();
  endtask

  task automatic test_register_masking();
    write_reg(RegUnused, '1);
    write_reg(REG_DEAD_BAND_EN, 16'hfffe);
    cfg_we <= 1'b0;
    send_sample(3, 3);
    settle();
  endtask

  task automatic test_extremes();
    pid_settings_t s;
    s = '{default: 0};
    s.gain_p = 32767;
    s.gain_i = -32768;
    s.gain_d = 32767;
    s.integ_lim = '1;
    s.out_lim = '1;
    s.band = '1;
    load_settings(s);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(32767, -32768);
    send_sample(0, 0);
    send_sample(-32768, 32767);
    settle();
    s.gain_p = -32768;
    s.gain_i = 32767;
    s.gain_d = -32768;
    s.out_lim = 1;
    load_settings(s);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(0, 0);
    settle();
  endtask

  task automatic test_zero_limits();
    pid_settings_t s;
    s = '{default: 0};
    s.gain_p = 256;
    s.gain_i = 256;
    s.gain_d = 256;
    load_settings(s);
    send_sample(0, 1000);
    send_sample(1000, -1000);
    send_sample(-32768, 32767);
    settle();
  endtask

  task automatic test_deadband_edges();
    pid_settings_t s;
    s = '{default: 0};
    s.gain_p = 256;
    s.out_lim = '1;
    s.band = 100;
    s.band_en = 1'b1;
    load_settings(s);
    send_sample(0, 101);
    send_sample(0, 100);
    send_sample(100, 0);
    send_sample(101, 0);
    send_sample(0, 0);
    settle();
    // widest band holds even the largest error
    s.band = '1;
    load_settings(s);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    settle();
  endtask

  task automatic test_random_phases();
    pid_settings_t s;
    stim_mode_t mode;
    int unsigned sent;
    int unsigned phase;
    int unsigned n_items;
    int unsigned r;
    int anchor;
    int w;
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      s.gain_p = pick_gain();
      s.gain_i = pick_gain();
      s.gain_d = pick_gain();
      s.integ_lim = pick_limit();
      s.out_lim = pick_limit();
      s.band = pick_band();
      s.band_en = 1'($urandom_range(1));
      load_settings(s);
      r = $urandom_range(9);
      mode = (r < 2) ? STIM_SPREAD : (r == 2) ? STIM_EDGES : STIM_TRACK;
      no_idle = (phase == 4 || phase == 5);
      // stall the result side long enough for the input to back up
      if (phase == 5) hold_off_req = 1'b1;
      n_items = $urandom_range(30, 70);
      anchor = int'(sample_t'($urandom));
      w = ((s.band > 40) ? 40 : int'(s.band)) + 3;
      repeat (n_items) begin
        case (mode)
          STIM_SPREAD: send_sample(sample_t'($urandom), sample_t'($urandom));
          STIM_EDGES:  send_sample(pick_edge_sample(), pick_edge_sample());
          default: begin
            if ($urandom_range(11) == 0) anchor = int'(sample_t'($urandom));
            send_sample(to_sample(anchor + int'($urandom_range(2 * w)) - w),
                        to_sample(anchor));
          end
        endcase
      end
      sent += n_items;
      settle();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // result side readiness, with one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t ns: transaction with no prediction pending, drive %0d held %0b",
                 $time, out_drive, out_held);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive) begin
          $display("%0t ns: drive expected %0d, got %0d", $time, want.drive, out_drive);
          mismatches++;
        end
        if (out_held !== want.held) begin
          $display("%0t ns: held expected %0b, got %0b", $time, want.held, out_held);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hold_from_reset();
    test_register_masking();
    test_extremes();
    test_zero_limits();
    test_deadband_edges();
    test_random_phases();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pid_pkg.sv
rtl/positional_pid_controller.sv
bench/tb_positional_pid_controller.sv
